[hw/rtl/nghs_pkg.sv]
package nghs_pkg;

  // Grid shape
  localparam int GRID_ROWS = 19;
  localparam int GRID_COLS = 17;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 5;

  // Configuration register indexes
  localparam logic [2:0] CFG_HOLE_OFFSET_X = 3'd0;
  localparam logic [2:0] CFG_HOLE_OFFSET_Y = 3'd1;
  localparam logic [2:0] CFG_HOLE_OFFSET_Z = 3'd2;
  localparam logic [2:0] CFG_PITCH_X       = 3'd3;
  localparam logic [2:0] CFG_PITCH_Y       = 3'd4;

  // Configuration reset values, Q7.16
  localparam logic signed [23:0] RST_HOLE_OFFSET_X = 24'sd2621440;
  localparam logic signed [23:0] RST_HOLE_OFFSET_Y = 24'sd1985741;
  localparam logic signed [23:0] RST_HOLE_OFFSET_Z = 24'sd1966080;
  localparam logic signed [23:0] RST_PITCH_X       = -24'sd327680;
  localparam logic signed [23:0] RST_PITCH_Y       = -24'sd283771;

  // Input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Identity element, Q15.16
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  // Label bias for columns
  localparam logic [COL_W-1:0] LABEL_SPLIT = 5'd7;
  localparam logic [COL_W-1:0] BIAS_LOW    = 5'd7;
  localparam logic [COL_W-1:0] BIAS_HIGH   = 5'd8;

endpackage

[hw/rtl/nearest_grid_hole_search.sv]
// Nearest grid hole search. A load beat (tuser cmd 0) writes one row of the 3x4
// registration transform. A query beat (tuser cmd 1) walks the staggered hole
// grid (even rows one hole short) through one shared signed multiplier: each
// hole takes nine transform products, three squared differences, pipeline fill
// and the compare, and the default 19x17 grid has 313 holes; then a
// digit-by-digit square root runs and the output register is loaded. The input
// is not ready while a query is in flight; a finished result waits in the output
// register.
module nearest_grid_hole_search (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // value_a [31:0], value_b [63:32], value_c [95:64], value_d [127:96]
  input  logic [127:0] s_tdata,
  // cmd [0], row_select [2:1]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hole_row [4:0], hole_col [9:5], label_col [14:10], distance [45:15],
  // hole_x [77:46], hole_y [109:78], hole_z [141:110], zero pad [143:142]
  output logic [143:0] m_tdata
);
  import nghs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [3:0] STEP_LAST_PROD = 4'd8;
  localparam logic [3:0] STEP_LAST_MAP  = 4'd9;
  localparam logic [3:0] STEP_SQ0       = 4'd10;
  localparam logic [3:0] STEP_SQ1       = 4'd11;
  localparam logic [3:0] STEP_SQ2       = 4'd12;
  localparam logic [3:0] STEP_CMP       = 4'd13;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLS - 1);

  logic [1:0] state;
  logic [3:0] step;

  logic signed [23:0] hox, hoy, hoz, px, py;
  logic signed [31:0] regs [12];

  logic signed [31:0] tgt [3];
  logic signed [31:0] hpos [3];
  logic signed [31:0] ox, oy;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic [1:0]         cur_r, cur_e, p_r, p_e;
  logic signed [49:0] acc;
  logic [68:0]        sum, best, sum_fin;
  logic               have;
  logic [ROW_W-1:0]   best_r;
  logic [COL_W-1:0]   best_c;
  logic signed [31:0] best_h [3];

  logic [61:0] sq_v;
  logic [32:0] rem;
  logic [30:0] root;
  logic [4:0]  sq_cnt;
  logic        sq_sat;

  logic signed [31:0] oz;
  logic signed [49:0] rnd;
  logic signed [49:0] map_sum;
  logic signed [31:0] map_sat;
  logic signed [32:0] diff;
  logic [1:0]         sq_k;
  logic               even_row;
  logic [COL_W-1:0]   row_last_col;
  logic [34:0]        rem2;
  logic [32:0]        trial;
  logic [COL_W-1:0]   label;

  assign s_tready = (state == ST_IDLE);
  assign oz       = 32'(hoz) <<< 1;
  assign even_row = ~row[0];
  assign row_last_col = even_row ? LAST_COL - 1'b1 : LAST_COL;

  // Map the issue step onto a transform row and element
  always_comb begin
    case (step)
      4'd0:    begin cur_r = 2'd0; cur_e = 2'd0; end
      4'd1:    begin cur_r = 2'd0; cur_e = 2'd1; end
      4'd2:    begin cur_r = 2'd0; cur_e = 2'd2; end
      4'd3:    begin cur_r = 2'd1; cur_e = 2'd0; end
      4'd4:    begin cur_r = 2'd1; cur_e = 2'd1; end
      4'd5:    begin cur_r = 2'd1; cur_e = 2'd2; end
      4'd6:    begin cur_r = 2'd2; cur_e = 2'd0; end
      4'd7:    begin cur_r = 2'd2; cur_e = 2'd1; end
      4'd8:    begin cur_r = 2'd2; cur_e = 2'd2; end
      default: begin cur_r = 2'd0; cur_e = 2'd0; end
    endcase
  end

  // Select multiplier operands: transform product or squared difference
  always_comb begin
    sq_k = 2'(step - STEP_SQ0);
    diff = 33'(hpos[sq_k]) - 33'(tgt[sq_k]);
    if (step <= STEP_LAST_PROD) begin
      mul_a = 34'(regs[{cur_r, cur_e}]);
      case (cur_e)
        2'd0:    mul_b = 34'(ox);
        2'd1:    mul_b = 34'(oy);
        default: mul_b = 34'(oz);
      endcase
    end else begin
      mul_a = 34'(diff);
      mul_b = 34'(diff);
    end
  end

  // Round a product to Q15.16 and close a transform row with saturation
  always_comb begin
    rnd     = 50'((prod + 68'sd65536) >>> 17);
    map_sum = acc + rnd + 50'(regs[{p_r, 2'd3}]);
    if (map_sum > 50'sh7FFFFFFF)
      map_sat = 32'sh7FFFFFFF;
    else if (map_sum < -50'sh80000000)
      map_sat = -32'sh80000000;
    else
      map_sat = 32'(map_sum);
    sum_fin = sum + 69'(prod[66:0]);
  end

  // One restoring square root digit
  always_comb begin
    rem2  = {rem[32:0], sq_v[61:60]};
    trial = {root, 2'b01};
  end

  assign label = best_c - (((~best_r[0]) && (best_c > LABEL_SPLIT)) ? BIAS_LOW : BIAS_HIGH);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hox <= RST_HOLE_OFFSET_X;
      hoy <= RST_HOLE_OFFSET_Y;
      hoz <= RST_HOLE_OFFSET_Z;
      px  <= RST_PITCH_X;
      py  <= RST_PITCH_Y;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOLE_OFFSET_X: hox <= cfg_data;
        CFG_HOLE_OFFSET_Y: hoy <= cfg_data;
        CFG_HOLE_OFFSET_Z: hoz <= cfg_data;
        CFG_PITCH_X:       px  <= cfg_data;
        CFG_PITCH_Y:       py  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Registration transform, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 12; k++)
        regs[k] <= ((k == 0) || (k == 5) || (k == 10)) ? ONE_Q16 : 32'sd0;
    end else if (s_tvalid && s_tready && (s_tuser[0] == CMD_LOAD) && (s_tuser[2:1] != 2'd3)) begin
      regs[{s_tuser[2:1], 2'd0}] <= s_tdata[31:0];
      regs[{s_tuser[2:1], 2'd1}] <= s_tdata[63:32];
      regs[{s_tuser[2:1], 2'd2}] <= s_tdata[95:64];
      regs[{s_tuser[2:1], 2'd3}] <= s_tdata[127:96];
    end
  end

  // Shared multiplier with registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    p_r  <= cur_r;
    p_e  <= cur_e;
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= 4'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE))
        m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid && (s_tuser[0] == CMD_QUERY)) begin
            tgt[0] <= s_tdata[31:0];
            tgt[1] <= s_tdata[63:32];
            tgt[2] <= s_tdata[95:64];
            row    <= '0;
            col    <= '0;
            ox     <= (32'(hox) <<< 1) + 32'(px);
            oy     <= 32'(hoy) <<< 1;
            have   <= 1'b0;
            step   <= 4'd0;
            state  <= ST_RUN;
          end
        end
        ST_RUN: begin
          // Fold transform products into the mapped position
          if ((step >= 4'd1) && (step <= STEP_LAST_MAP)) begin
            case (p_e)
              2'd0:    acc <= rnd;
              2'd1:    acc <= acc + rnd;
              default: hpos[p_r] <= map_sat;
            endcase
          end
          // Accumulate squared differences
          if (step == STEP_SQ1)
            sum <= 69'(prod[66:0]);
          else if (step == STEP_SQ2)
            sum <= sum_fin;
          if (step == STEP_CMP) begin
            if (!have || (sum_fin < best)) begin
              have      <= 1'b1;
              best      <= sum_fin;
              best_r    <= row;
              best_c    <= col;
              best_h[0] <= hpos[0];
              best_h[1] <= hpos[1];
              best_h[2] <= hpos[2];
            end
            step <= 4'd0;
            // Advance to the next hole
            if (col == row_last_col) begin
              col <= '0;
              oy  <= oy + (32'(py) <<< 1);
              ox  <= (32'(hox) <<< 1) + (row[0] ? 32'(px) : 32'sd0);
              row <= row + 1'b1;
              if (row == LAST_ROW)
                state <= ST_SQRT;
            end else begin
              col <= col + 1'b1;
              ox  <= ox + (32'(px) <<< 1);
            end
          end else begin
            step <= step + 1'b1;
          end
          if ((step == STEP_CMP) && (col == row_last_col) && (row == LAST_ROW)) begin
            sq_v   <= (!have || (sum_fin < best)) ? sum_fin[61:0] : best[61:0];
            if (!have || (sum_fin < best))
              sq_sat <= (sum_fin[68:62] != '0);
            else
              sq_sat <= (best[68:62] != '0);
            rem    <= '0;
            root   <= '0;
            sq_cnt <= '0;
          end
        end
        ST_SQRT: begin
          // Produce one root bit per cycle
          if (rem2 >= 35'(trial)) begin
            rem  <= 33'(rem2 - 35'(trial));
            root <= {root[29:0], 1'b1};
          end else begin
            rem  <= rem2[32:0];
            root <= {root[29:0], 1'b0};
          end
          sq_v   <= {sq_v[59:0], 2'b00};
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 5'd30)
            state <= ST_DONE;
        end
        default: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, best_h[2], best_h[1], best_h[0],
                         (sq_sat ? 31'h7FFFFFFF : root), label, best_c, best_r};
            state    <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule
